@@ rtl/stp_pkg.sv @@
// Shared constants, codes and types for the stepper position controller.
// Used by the command parser, the motion core and the top level.
// No dependencies.
package stp_pkg;

	localparam int unsigned MAX_CHARS = 30;

	localparam logic [1:0] MODE_ACTIVE   = 2'd0;
	localparam logic [1:0] MODE_INACTIVE = 2'd1;
	localparam logic [1:0] MODE_HOMING   = 2'd2;

	localparam logic [1:0] STAGE_LEADING = 2'd0;
	localparam logic [1:0] STAGE_DIGITS  = 2'd1;
	localparam logic [1:0] STAGE_DONE    = 2'd2;

	localparam logic [3:0] R_NONE   = 4'd0;
	localparam logic [3:0] R_POS    = 4'd1;
	localparam logic [3:0] R_PERIOD = 4'd2;
	localparam logic [3:0] R_ACT    = 4'd3;
	localparam logic [3:0] R_INACT  = 4'd4;
	localparam logic [3:0] R_ERR    = 4'd5;
	localparam logic [3:0] R_HOMING = 4'd6;
	localparam logic [3:0] R_RETURN = 4'd7;
	localparam logic [3:0] R_DONE   = 4'd8;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF_CR = 8'h0D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_W     = 8'h57;
	localparam logic [7:0] CH_H     = 8'h48;

	localparam logic [15:0] PERIOD_RESET   = 16'd5000;
	localparam logic [15:0] COMPARE_RESET  = 16'd5000;
	localparam logic [15:0] COMPARE_HOMING = 16'd10000;
	localparam logic [31:0] TICKS_PER_UNIT = 32'd6250;

	typedef struct packed {
		logic        valid;
		logic [7:0]  letter;
		logic [7:0]  second;
		logic [15:0] value;
	} exec_t;

	typedef struct packed {
		logic               cmd;
		logic [7:0]         rx_byte;
		logic               home_switch;
	} item_t;

	typedef struct packed {
		logic [3:0]         reply;
		logic signed [15:0] reply_value;
		logic               step_pin;
		logic               dir_pin;
		logic [15:0]        compare_value;
		logic signed [15:0] position_now;
		logic [1:0]         mode_now;
	} res_t;

endpackage

@@ rtl/stp_in_if.sv @@
// Input channel of the stepper controller: valid/ready with one item payload.
// No dependencies.
interface stp_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] rx_byte;
	logic       home_switch;

	modport source (output valid, cmd, rx_byte, home_switch, input ready);
	modport sink (input valid, cmd, rx_byte, home_switch, output ready);
endinterface

@@ rtl/stp_out_if.sv @@
// Result channel of the stepper controller: valid/ready with one result payload.
// No dependencies.
interface stp_out_if;
	logic               valid;
	logic               ready;
	logic [3:0]         reply;
	logic signed [15:0] reply_value;
	logic               step_pin;
	logic               dir_pin;
	logic [15:0]        compare_value;
	logic signed [15:0] position_now;
	logic [1:0]         mode_now;

	modport source (output valid, reply, reply_value, step_pin, dir_pin, compare_value,
		position_now, mode_now, input ready);
	modport sink (input valid, reply, reply_value, step_pin, dir_pin, compare_value,
		position_now, mode_now, output ready);
endinterface

@@ rtl/stepper_position_controller_top.sv @@
// Top level of the stepper position controller: input register, parser, motion core
// and result register. Depends on stp_pkg, stp_in_if, stp_out_if, stp_parser, stp_motion.
//
// Usage: every item on in_ch is either a received serial byte (cmd 0) or a timer
// tick (cmd 1, home_switch sampled). Exactly one result appears on out_ch for each
// item, in order, carrying the reply code, the acknowledged value and the pin,
// compare, position and mode levels after that item.
// An accepted item is held in the input register until the result register can take
// it; the parser and motion core process it combinationally as it leaves, and its
// result lands in the result register. Throughput is one item per cycle while the
// receiver does not stall; the state of the parser and motion core is updated in the
// single cycle an item leaves the input register.
// When the receiver stalls, the result register holds its result and the input
// register keeps one further item, so a second transfer is taken before in_ch
// ready drops. Ready returns in the same cycle that out_ch ready rises.
// Reset puts the controller inactive at position zero with period and compare
// word 5000, clears the parser and empties both registers.
module stepper_position_controller_top #(
	parameter int unsigned MAX_CHARS = stp_pkg::MAX_CHARS
) (
	input logic       clk,
	input logic       arst_n,
	stp_in_if.sink    in_ch,
	stp_out_if.source out_ch
);
	import stp_pkg::*;

	logic  valid_s1, valid_s2;
	item_t item_s1;
	res_t  res_s2, res_c;
	exec_t exec;
	logic  adv_s2, take_s1, in_xfer;

	assign adv_s2      = !valid_s2 || out_ch.ready;
	assign take_s1     = valid_s1 && adv_s2;
	assign in_ch.ready = !valid_s1 || adv_s2;
	assign in_xfer     = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_xfer) begin
				valid_s1 <= 1'b1;
			end else if (take_s1) begin
				valid_s1 <= 1'b0;
			end
			if (take_s1) begin
				valid_s2 <= 1'b1;
			end else if (out_ch.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1 <= '{cmd: in_ch.cmd, rx_byte: in_ch.rx_byte,
				home_switch: in_ch.home_switch};
		end
		if (take_s1) begin
			res_s2 <= res_c;
		end
	end

	stp_parser #(
		.MAX_CHARS (MAX_CHARS)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (take_s1),
		.cmd     (item_s1.cmd),
		.rx_byte (item_s1.rx_byte),
		.exec    (exec)
	);

	stp_motion u_motion (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (take_s1),
		.cmd         (item_s1.cmd),
		.home_switch (item_s1.home_switch),
		.exec        (exec),
		.res         (res_c)
	);

	assign out_ch.valid         = valid_s2;
	assign out_ch.reply         = res_s2.reply;
	assign out_ch.reply_value   = res_s2.reply_value;
	assign out_ch.step_pin      = res_s2.step_pin;
	assign out_ch.dir_pin       = res_s2.dir_pin;
	assign out_ch.compare_value = res_s2.compare_value;
	assign out_ch.position_now  = res_s2.position_now;
	assign out_ch.mode_now      = res_s2.mode_now;

	property p_value_only_on_ack;
		@(posedge clk) disable iff (!arst_n)
			valid_s2 && res_s2.reply != R_POS && res_s2.reply != R_PERIOD
				|-> res_s2.reply_value == 16'sd0;
	endproperty
	a_value_only_on_ack: assert property (p_value_only_on_ack)
		else $error("reply value without acknowledge");

	property p_ready_when_empty;
		@(posedge clk) disable iff (!arst_n) !valid_s2 |-> in_ch.ready;
	endproperty
	a_ready_when_empty: assert property (p_ready_when_empty)
		else $error("input stalled with empty result register");

	property p_take_fills_result;
		@(posedge clk) disable iff (!arst_n) take_s1 |=> valid_s2;
	endproperty
	a_take_fills_result: assert property (p_take_fills_result)
		else $error("processed item lost");
endmodule

@@ rtl/stp_parser.sv @@
// Serial command parser: collects the command letter, second character and number.
// Issues an execute request on a carriage return. Depends on stp_pkg.
module stp_parser #(
	parameter int unsigned MAX_CHARS = stp_pkg::MAX_CHARS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  logic           cmd,
	input  logic [7:0]     rx_byte,
	output stp_pkg::exec_t exec
);
	import stp_pkg::*;

	logic [7:0]  letter_q, second_q, letter_d, second_d;
	logic [4:0]  count_q, count_d;
	logic [15:0] accum_q, accum_d;
	logic        neg_q, neg_d;
	logic [1:0]  stage_q, stage_d;
	logic        is_digit, is_blank;
	logic [15:0] digit_val, accum_x10;

	assign is_digit  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
	assign is_blank  = (rx_byte == CH_SPACE) || ((rx_byte >= CH_TAB) && (rx_byte <= CH_LF_CR));
	assign digit_val = {8'd0, rx_byte - CH_ZERO};
	assign accum_x10 = (accum_q << 3) + (accum_q << 1);

	always_comb begin
		letter_d = letter_q;
		second_d = second_q;
		count_d  = count_q;
		accum_d  = accum_q;
		neg_d    = neg_q;
		stage_d  = stage_q;
		if (!cmd) begin
			if (rx_byte == CH_COLON) begin
				letter_d = '0;
				second_d = '0;
				count_d  = '0;
				accum_d  = '0;
				neg_d    = 1'b0;
				stage_d  = STAGE_LEADING;
			end else if (rx_byte != CH_CR && 32'(count_q) < MAX_CHARS) begin
				if (count_q == 5'd0) begin
					letter_d = rx_byte;
				end else begin
					if (count_q == 5'd1) begin
						second_d = rx_byte;
					end
					if (rx_byte == 8'd0) begin
						stage_d = STAGE_DONE;
					end else if (stage_q == STAGE_LEADING) begin
						if (!is_blank) begin
							if (rx_byte == CH_PLUS) begin
								stage_d = STAGE_DIGITS;
							end else if (rx_byte == CH_MINUS) begin
								neg_d   = 1'b1;
								stage_d = STAGE_DIGITS;
							end else if (is_digit) begin
								accum_d = digit_val;
								stage_d = STAGE_DIGITS;
							end else begin
								stage_d = STAGE_DONE;
							end
						end
					end else if (stage_q == STAGE_DIGITS) begin
						if (is_digit) begin
							accum_d = accum_x10 + digit_val;
						end else begin
							stage_d = STAGE_DONE;
						end
					end
				end
				count_d = count_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			letter_q <= '0;
			second_q <= '0;
			count_q  <= '0;
			accum_q  <= '0;
			neg_q    <= 1'b0;
			stage_q  <= STAGE_LEADING;
		end else if (fire) begin
			letter_q <= letter_d;
			second_q <= second_d;
			count_q  <= count_d;
			accum_q  <= accum_d;
			neg_q    <= neg_d;
			stage_q  <= stage_d;
		end
	end

	assign exec.valid  = !cmd && (rx_byte == CH_CR);
	assign exec.letter = letter_q;
	assign exec.second = second_q;
	assign exec.value  = neg_q ? (16'd0 - accum_q) : accum_q;

	property p_count_limit;
		@(posedge clk) disable iff (!arst_n) 32'(count_q) <= MAX_CHARS;
	endproperty
	a_count_limit: assert property (p_count_limit) else $error("char count past limit");

	property p_stage_code;
		@(posedge clk) disable iff (!arst_n) stage_q != 2'd3;
	endproperty
	a_stage_code: assert property (p_stage_code) else $error("bad parse stage");

	property p_colon_clears;
		@(posedge clk) disable iff (!arst_n)
			fire && !cmd && rx_byte == CH_COLON |=> count_q == 5'd0 && letter_q == 8'd0;
	endproperty
	a_colon_clears: assert property (p_colon_clears) else $error("restart did not clear");
endmodule

@@ rtl/stp_motion.sv @@
// Motion core: mode, positions, timer compare word and pin levels.
// Executes parsed commands and timer ticks. Depends on stp_pkg.
module stp_motion (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  logic           cmd,
	input  logic           home_switch,
	input  stp_pkg::exec_t exec,
	output stp_pkg::res_t  res
);
	import stp_pkg::*;

	logic [1:0]  mode_q, mode_d;
	logic [15:0] target_q, target_d, pos_q, pos_d;
	logic [15:0] period_q, period_d, compare_q, compare_d;
	logic        latch_q, latch_d, step_q, step_d, dir_q, dir_d;
	logic [3:0]  reply;
	logic [15:0] value;
	logic [31:0] product;

	assign product = {16'd0, exec.value} * TICKS_PER_UNIT;

	always_comb begin
		mode_d    = mode_q;
		target_d  = target_q;
		pos_d     = pos_q;
		period_d  = period_q;
		compare_d = compare_q;
		latch_d   = latch_q;
		step_d    = step_q;
		dir_d     = dir_q;
		reply     = R_NONE;
		value     = '0;
		if (cmd) begin
			if (mode_q == MODE_ACTIVE) begin
				if (pos_q != target_q) begin
					if ($signed(target_q) < $signed(pos_q)) begin
						dir_d = 1'b0;
						pos_d = pos_q - 16'd1;
					end else begin
						dir_d = 1'b1;
						pos_d = pos_q + 16'd1;
					end
					step_d = !step_q;
				end
			end else if (mode_q == MODE_INACTIVE) begin
				step_d = 1'b0;
			end else if (mode_q == MODE_HOMING) begin
				if (home_switch) begin
					if (latch_q) begin
						dir_d  = 1'b0;
						step_d = !step_q;
						pos_d  = pos_q - 16'd1;
						reply  = R_HOMING;
					end else begin
						target_d  = '0;
						pos_d     = '0;
						compare_d = COMPARE_RESET;
						mode_d    = MODE_ACTIVE;
						reply     = R_DONE;
					end
				end else begin
					latch_d = 1'b0;
					dir_d   = 1'b1;
					step_d  = !step_q;
					pos_d   = pos_q + 16'd1;
					reply   = R_RETURN;
				end
			end
		end else if (exec.valid) begin
			case (exec.letter)
				CH_P: begin
					if (exec.second != 8'd0 && mode_q == MODE_ACTIVE) begin
						target_d = exec.value;
						reply    = R_POS;
						value    = exec.value;
					end else if (mode_q == MODE_INACTIVE) begin
						reply = R_ERR;
					end
				end
				CH_T: begin
					if (exec.second != 8'd0 && mode_q == MODE_ACTIVE) begin
						period_d  = exec.value;
						compare_d = product[15:0];
						reply     = R_PERIOD;
						value     = exec.value;
					end else if (mode_q == MODE_INACTIVE) begin
						reply = R_ERR;
					end
				end
				CH_W: begin
					if (exec.second == CH_ONE) begin
						mode_d = MODE_ACTIVE;
						reply  = R_ACT;
					end else if (exec.second == CH_ZERO) begin
						mode_d = MODE_INACTIVE;
						reply  = R_INACT;
					end else if (exec.second != 8'd0) begin
						reply = R_ERR;
					end
				end
				CH_H: begin
					if (mode_q == MODE_ACTIVE) begin
						mode_d    = MODE_HOMING;
						compare_d = COMPARE_HOMING;
						latch_d   = 1'b1;
					end else if (mode_q == MODE_INACTIVE) begin
						reply = R_ERR;
					end
				end
				default: reply = R_ERR;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_INACTIVE;
			target_q  <= '0;
			pos_q     <= '0;
			period_q  <= PERIOD_RESET;
			compare_q <= COMPARE_RESET;
			latch_q   <= 1'b0;
			step_q    <= 1'b0;
			dir_q     <= 1'b0;
		end else if (fire) begin
			mode_q    <= mode_d;
			target_q  <= target_d;
			pos_q     <= pos_d;
			period_q  <= period_d;
			compare_q <= compare_d;
			latch_q   <= latch_d;
			step_q    <= step_d;
			dir_q     <= dir_d;
		end
	end

	assign res.reply         = reply;
	assign res.reply_value   = $signed(value);
	assign res.step_pin      = step_d;
	assign res.dir_pin       = dir_d;
	assign res.compare_value = compare_d;
	assign res.position_now  = $signed(pos_d);
	assign res.mode_now      = mode_d;

	property p_mode_code;
		@(posedge clk) disable iff (!arst_n) mode_q != 2'd3;
	endproperty
	a_mode_code: assert property (p_mode_code) else $error("unused mode reached");

	property p_inactive_step_low;
		@(posedge clk) disable iff (!arst_n)
			fire && cmd && mode_q == MODE_INACTIVE |=> !step_q;
	endproperty
	a_inactive_step_low: assert property (p_inactive_step_low)
		else $error("step level high after inactive tick");

	property p_done_zeroes;
		@(posedge clk) disable iff (!arst_n)
			fire && reply == R_DONE |=> pos_q == 16'd0 && target_q == 16'd0
				&& mode_q == MODE_ACTIVE;
	endproperty
	a_done_zeroes: assert property (p_done_zeroes) else $error("homing done did not zero");
endmodule

@@ tb/stepper_position_controller_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for stepper_position_controller_top: serial command bytes
// and timer ticks go in, and every status result is checked against an in-bench model.
// Depends on stp_pkg, stp_in_if, stp_out_if and the controller RTL.
module stepper_position_controller_top_tb;
	import stp_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;

	logic clk;
	logic arst_n;

	stp_in_if  in_ch();
	stp_out_if out_ch();

	stepper_position_controller_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	logic [1:0]  ctl_mode;
	logic [15:0] ctl_target;
	logic [15:0] ctl_pos;
	logic        ctl_latch;
	logic [15:0] ctl_period;
	logic [15:0] ctl_compare;
	logic        ctl_step;
	logic        ctl_dir;
	logic [7:0]  cmd_letter;
	logic [7:0]  cmd_second;
	logic [4:0]  cmd_count;
	logic [15:0] num_accum;
	logic        num_neg;
	logic [1:0]  num_stage;

	res_t status_queue[$];
	int   items_sent;
	int   stall_cycles;
	bit   failed;
	bit   steady_run;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic bit take_break();
		return !steady_run && ($urandom_range(99) < 6);
	endfunction

	task automatic clear_command();
		cmd_letter = '0;
		cmd_second = '0;
		cmd_count  = '0;
		num_accum  = '0;
		num_neg    = 1'b0;
		num_stage  = STAGE_LEADING;
	endtask

	task automatic reset_controller();
		ctl_mode    = MODE_INACTIVE;
		ctl_target  = '0;
		ctl_pos     = '0;
		ctl_latch   = 1'b0;
		ctl_period  = PERIOD_RESET;
		ctl_compare = COMPARE_RESET;
		ctl_step    = 1'b0;
		ctl_dir     = 1'b0;
		clear_command();
	endtask

	task automatic step_controller(input item_t it, output res_t r);
		logic [3:0]  rep;
		logic [15:0] val;
		logic [15:0] num;
		logic [31:0] prod;
		logic [7:0]  c;
		bit          is_digit;
		rep = R_NONE;
		val = '0;
		c = it.rx_byte;
		is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
		num = num_neg ? (16'd0 - num_accum) : num_accum;
		if (it.cmd) begin
			case (ctl_mode)
				MODE_ACTIVE: begin
					if (ctl_pos != ctl_target) begin
						if ($signed(ctl_target) < $signed(ctl_pos)) begin
							ctl_dir = 1'b0;
							ctl_pos = ctl_pos - 16'd1;
						end else begin
							ctl_dir = 1'b1;
							ctl_pos = ctl_pos + 16'd1;
						end
						ctl_step = ~ctl_step;
					end
				end
				MODE_INACTIVE: ctl_step = 1'b0;
				MODE_HOMING: begin
					if (it.home_switch) begin
						if (ctl_latch) begin
							ctl_dir  = 1'b0;
							ctl_step = ~ctl_step;
							ctl_pos  = ctl_pos - 16'd1;
							rep      = R_HOMING;
						end else begin
							ctl_target  = '0;
							ctl_pos     = '0;
							ctl_compare = COMPARE_RESET;
							ctl_mode    = MODE_ACTIVE;
							rep         = R_DONE;
						end
					end else begin
						ctl_latch = 1'b0;
						ctl_dir   = 1'b1;
						ctl_step  = ~ctl_step;
						ctl_pos   = ctl_pos + 16'd1;
						rep       = R_RETURN;
					end
				end
				default: ;
			endcase
		end else if (c == CH_COLON) begin
			clear_command();
		end else if (c == CH_CR) begin
			case (cmd_letter)
				CH_P: begin
					if (cmd_second != 8'd0 && ctl_mode == MODE_ACTIVE) begin
						ctl_target = num;
						rep = R_POS;
						val = num;
					end else if (ctl_mode == MODE_INACTIVE) begin
						rep = R_ERR;
					end
				end
				CH_T: begin
					if (cmd_second != 8'd0 && ctl_mode == MODE_ACTIVE) begin
						ctl_period = num;
						prod = ctl_period * TICKS_PER_UNIT;
						ctl_compare = prod[15:0];
						rep = R_PERIOD;
						val = num;
					end else if (ctl_mode == MODE_INACTIVE) begin
						rep = R_ERR;
					end
				end
				CH_W: begin
					if (cmd_second == CH_ONE) begin
						ctl_mode = MODE_ACTIVE;
						rep = R_ACT;
					end else if (cmd_second == CH_ZERO) begin
						ctl_mode = MODE_INACTIVE;
						rep = R_INACT;
					end else if (cmd_second != 8'd0) begin
						rep = R_ERR;
					end
				end
				CH_H: begin
					if (ctl_mode == MODE_ACTIVE) begin
						ctl_mode    = MODE_HOMING;
						ctl_compare = COMPARE_HOMING;
						ctl_latch   = 1'b1;
					end else if (ctl_mode == MODE_INACTIVE) begin
						rep = R_ERR;
					end
				end
				default: rep = R_ERR;
			endcase
		end else if (cmd_count < MAX_CHARS) begin
			if (cmd_count == 5'd0) begin
				cmd_letter = c;
			end else begin
				if (cmd_count == 5'd1)
					cmd_second = c;
				if (c == 8'd0) begin
					num_stage = STAGE_DONE;
				end else if (num_stage == STAGE_LEADING) begin
					if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
						num_stage = (c == CH_PLUS || c == CH_MINUS || is_digit) ?
							STAGE_DIGITS : STAGE_DONE;
						if (c == CH_MINUS)
							num_neg = 1'b1;
						if (is_digit)
							num_accum = {8'd0, c - CH_ZERO};
					end
				end else if (num_stage == STAGE_DIGITS) begin
					if (is_digit)
						num_accum = num_accum * 16'd10 + {8'd0, c - CH_ZERO};
					else
						num_stage = STAGE_DONE;
				end
			end
			cmd_count = cmd_count + 5'd1;
		end
		r.reply         = rep;
		r.reply_value   = val;
		r.step_pin      = ctl_step;
		r.dir_pin       = ctl_dir;
		r.compare_value = ctl_compare;
		r.position_now  = ctl_pos;
		r.mode_now      = ctl_mode;
	endtask

	task automatic send_item(input logic is_tick, input logic [7:0] b, input logic sw);
		item_t it;
		res_t  r;
		it.cmd = is_tick;
		it.rx_byte = b;
		it.home_switch = sw;
		@(negedge clk);
		while (take_break()) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.cmd         <= is_tick;
		in_ch.rx_byte     <= b;
		in_ch.home_switch <= sw;
		do
			@(posedge clk);
		while (!in_ch.ready);
		step_controller(it, r);
		status_queue.push_back(r);
		items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] c);
		send_item(1'b0, c, 1'($urandom_range(1)));
	endtask

	task automatic send_tick(input logic sw);
		send_item(1'b1, 8'($urandom_range(255)), sw);
	endtask

	task automatic send_command(input string body);
		send_byte(CH_COLON);
		for (int i = 0; i < body.len(); i++)
			send_byte(body[i]);
		send_byte(CH_CR);
	endtask

	task automatic hold_until_drained();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (status_queue.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_random_number();
		int n;
		repeat ($urandom_range(2))
			send_byte($urandom_range(1) ? CH_SPACE : 8'(CH_TAB + $urandom_range(3)));
		case ($urandom_range(3))
			0: send_byte(CH_PLUS);
			1: send_byte(CH_MINUS);
			default: ;
		endcase
		n = ($urandom_range(4) == 0) ? $urandom_range(6) : $urandom_range(1, 2);
		repeat (n)
			send_byte(8'(CH_ZERO + $urandom_range(9)));
		if ($urandom_range(4) == 0)
			send_byte(8'($urandom_range(255)));
	endtask

	task automatic send_random_command();
		int         pick;
		logic [7:0] letter;
		pick = $urandom_range(99);
		if (pick < 35)
			letter = CH_P;
		else if (pick < 50)
			letter = CH_T;
		else if (pick < 75)
			letter = CH_W;
		else if (pick < 85)
			letter = CH_H;
		else
			letter = 8'($urandom_range(255));
		if (letter == CH_COLON || letter == CH_CR)
			letter = 8'd0;
		if ($urandom_range(9) != 0)
			send_byte(CH_COLON);
		send_byte(letter);
		if (letter == CH_W) begin
			pick = $urandom_range(9);
			if (pick < 6)
				send_byte(CH_ONE);
			else if (pick < 8)
				send_byte(CH_ZERO);
			else if (pick == 8)
				send_byte(8'($urandom_range(255)));
		end else if (letter == CH_P || letter == CH_T) begin
			if ($urandom_range(9) != 0)
				send_random_number();
		end else if ($urandom_range(3) == 0) begin
			send_byte(8'($urandom_range(255)));
		end
		send_byte(CH_CR);
		if ($urandom_range(9) == 0)
			send_byte(CH_CR);
	endtask

	task automatic send_random_action();
		int pick;
		pick = $urandom_range(99);
		if (pick < 45) begin
			send_random_command();
		end else if (pick < 88) begin
			repeat ($urandom_range(1, 12))
				send_tick($urandom_range(99) < 60);
		end else begin
			repeat ($urandom_range(1, 40))
				send_byte(8'($urandom_range(255)));
		end
	endtask

	task automatic test_power_up();
		send_tick(1'b1);
		send_byte(CH_CR);
		send_command("P5");
		send_command("H");
	endtask

	task automatic test_motion();
		send_command("W1");
		send_command("P-2");
		repeat (3)
			send_tick(1'b0);
		send_command("T65535");
		send_command("T0");
		send_command("P32767");
		send_tick(1'b1);
	endtask

	task automatic test_homing();
		send_command("H");
		send_command("H");
		send_command("P7");
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b1);
	endtask

	task automatic test_parser();
		send_command("X");
		send_command("W2");
		send_command("W");
		send_command("P");
		send_byte(CH_COLON);
		send_byte(8'd0);
		send_byte(CH_CR);
		send_command("P-32768");
		send_byte(CH_CR);
		send_byte(CH_COLON);
		send_byte(CH_T);
		send_byte(CH_TAB);
		send_byte(CH_PLUS);
		send_command("12a3");
		send_byte(CH_COLON);
		send_byte(CH_T);
		repeat (32)
			send_byte(CH_NINE);
		send_byte(CH_CR);
	endtask

	task automatic test_disable();
		send_command("W0");
		send_tick(1'b0);
	endtask

	task automatic test_random();
		steady_run = 1'b1;
		while (items_sent < 600)
			send_random_action();
		steady_run = 1'b0;
		hold_until_drained();
		while (items_sent < 1750)
			send_random_action();
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			failed = 1'b1;
		end
	endtask

	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (status_queue.size() == 0) begin
				$error("result transfer with no expected result");
				failed = 1'b1;
			end else begin
				want = status_queue.pop_front();
				check_field("reply", 16'(want.reply), 16'(out_ch.reply));
				check_field("reply_value", want.reply_value, out_ch.reply_value);
				check_field("step_pin", 16'(want.step_pin), 16'(out_ch.step_pin));
				check_field("dir_pin", 16'(want.dir_pin), 16'(out_ch.dir_pin));
				check_field("compare_value", want.compare_value, out_ch.compare_value);
				check_field("position_now", want.position_now, out_ch.position_now);
				check_field("mode_now", 16'(want.mode_now), 16'(out_ch.mode_now));
			end
		end
	end

	always @(negedge clk)
		out_ch.ready <= !take_break();

	initial begin
		stall_cycles = 0;
		while (stall_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.cmd = 1'b0;
		in_ch.rx_byte = '0;
		in_ch.home_switch = 1'b0;
		out_ch.ready = 1'b0;
		failed = 1'b0;
		steady_run = 1'b0;
		items_sent = 0;
		reset_controller();
		repeat (8)
			@(negedge clk);
		arst_n = 1'b1;
		test_power_up();
		test_motion();
		test_homing();
		test_parser();
		test_disable();
		test_random();
		hold_until_drained();
		repeat (8)
			@(posedge clk);
		if (!failed && status_queue.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ files.f @@
rtl/stp_pkg.sv
rtl/stp_in_if.sv
rtl/stp_out_if.sv
rtl/stp_parser.sv
rtl/stp_motion.sv
rtl/stepper_position_controller_top.sv
tb/stepper_position_controller_top_tb.sv
